// ----- hdl/first_match_packet_filter_core_macros.svh -----
// Assertion helpers used by the filter core RTL.
`ifndef FIRST_MATCH_PACKET_FILTER_CORE_MACROS_SVH
`define FIRST_MATCH_PACKET_FILTER_CORE_MACROS_SVH

// Same-cycle implication, checked on clk and masked during reset.
`define FMPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("filter check failed");

// Next-cycle implication, checked on clk and masked during reset.
`define FMPF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("filter check failed");

`endif

// ----- hdl/fmpf_pkg.sv -----
package fmpf_pkg;

  localparam int RULES = 32;
  localparam int CNT_W = $clog2(RULES + 1);

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_CLASSIFY = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] V_ACCEPT = 2'd0;
  localparam logic [1:0] V_DROP   = 2'd1;
  localparam logic [1:0] V_REJECT = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  proto;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] l4_port;
    logic [1:0]  rule_verdict;
    logic [4:0]  rule_index;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  verdict;
    logic [5:0]  matched_rule;
    logic [63:0] hit_cnt;
    logic [63:0] packets_in;
    logic [63:0] packets_dropped;
    logic [5:0]  rule_count;
  } out_res_t;

  // Request token that walks the rule chain one cell per cycle.
  typedef struct packed {
    logic             vld;
    logic [1:0]       op;
    logic [7:0]       proto;
    logic [31:0]      src;
    logic [31:0]      dst;
    logic [15:0]      port;
    logic [1:0]       act;
    logic [4:0]       idx;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] count;
    logic             found;
    logic [1:0]       verdict;
    logic [CNT_W-1:0] match;
    logic [63:0]      hits;
  } tok_t;

  function automatic logic [5:0] to_w6(input logic [CNT_W-1:0] v);
    logic [CNT_W+5:0] w;
    w = (CNT_W + 6)'(v);
    return w[5:0];
  endfunction

endpackage

// ----- hdl/first_match_packet_filter_core.sv -----
// First-match packet filter. Rules live in a chain of RULES cells, one rule per
// cell; a request walks the chain one cell per clock, so every request (add,
// classify, read) puts its single result on out_res after it leaves the last cell
// and passes the result register. busy falls at the edge that shows the result,
// so the next request can be taken at the edge that ends the result cycle; no
// new request is taken while one is in the chain. The result appears on out_res
// with out_strobe high for exactly one cycle; the receiver cannot stall it and
// must take it in that cycle. Counters wrap at 64 bits.
`include "first_match_packet_filter_core_macros.svh"

module first_match_packet_filter_core
  import fmpf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_strobe,
  output out_res_t out_res
);

  tok_t             tok_w [RULES+1];
  tok_t             tail;
  logic             accept;
  logic             busy_r;
  logic             out_strobe_r;
  out_res_t         out_res_r, res_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [63:0]      seen_r, seen_nxt;
  logic [63:0]      drop_r, drop_nxt;
  logic [RULES:0]   vld_vec;

  assign accept = start && !busy_r;

  always_comb begin
    tok_w[0]         = '0;
    tok_w[0].vld     = accept;
    tok_w[0].op      = in_req.op;
    tok_w[0].proto   = in_req.proto;
    tok_w[0].src     = in_req.src_ip;
    tok_w[0].dst     = in_req.dst_ip;
    tok_w[0].port    = in_req.l4_port;
    tok_w[0].act     = in_req.rule_verdict;
    tok_w[0].idx     = in_req.rule_index;
    tok_w[0].count   = cnt_r;
  end

  for (genvar g = 0; g < RULES; g++) begin : g_cell
    fmpf_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok_w[g]),
      .tok_o (tok_w[g+1])
    );
  end

  always_comb begin
    for (int k = 0; k <= RULES; k++) begin
      vld_vec[k] = tok_w[k].vld;
    end
  end

  assign tail = tok_w[RULES];

  always_comb begin
    res_nxt  = '0;
    cnt_nxt  = cnt_r;
    seen_nxt = seen_r;
    drop_nxt = drop_r;
    case (tail.op)
      OP_ADD: begin
        if (tail.count >= CNT_W'(RULES)) begin
          res_nxt.status = ST_FULL;
        end else begin
          cnt_nxt              = CNT_W'(tail.count + 1'b1);
          res_nxt.matched_rule = to_w6(cnt_nxt);
        end
      end
      OP_CLASSIFY: begin
        seen_nxt = seen_r + 64'd1;
        if (tail.found) begin
          res_nxt.verdict      = tail.verdict;
          res_nxt.matched_rule = to_w6(tail.match);
          res_nxt.hit_cnt      = tail.hits;
          if (tail.verdict == V_DROP || tail.verdict == V_REJECT) begin
            drop_nxt = drop_r + 64'd1;
          end
        end else begin
          // no rule matched: default drop
          res_nxt.verdict = V_DROP;
          drop_nxt        = drop_r + 64'd1;
        end
      end
      OP_READ: begin
        if (16'(tail.idx) >= 16'(tail.count)) begin
          res_nxt.status = ST_RANGE;
        end else begin
          res_nxt.matched_rule = {1'b0, tail.idx} + 6'd1;
          res_nxt.hit_cnt      = tail.hits;
        end
      end
      default: begin
      end
    endcase
    res_nxt.packets_in      = seen_nxt;
    res_nxt.packets_dropped = drop_nxt;
    res_nxt.rule_count      = to_w6(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_strobe_r <= 1'b0;
      cnt_r        <= '0;
      seen_r       <= 64'd0;
      drop_r       <= 64'd0;
    end else begin
      out_strobe_r <= tail.vld;
      if (tail.vld) begin
        busy_r <= 1'b0;
        cnt_r  <= cnt_nxt;
        seen_r <= seen_nxt;
        drop_r <= drop_nxt;
      end else if (accept) begin
        busy_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.vld) begin
      out_res_r <= res_nxt;
    end
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  `FMPF_ASSERT_NXT(a_accept_busy, accept, busy_r)
  `FMPF_ASSERT_IMP(a_strobe_idle, out_strobe_r, !busy_r)
  `FMPF_ASSERT_NXT(a_strobe_pulse, out_strobe_r, !out_strobe_r)
  `FMPF_ASSERT_IMP(a_one_token, 1'b1, $countones(vld_vec) <= 1)
  `FMPF_ASSERT_IMP(a_tail_busy, tail.vld, busy_r)

endmodule

// ----- hdl/fmpf_cell.sv -----
module fmpf_cell
  import fmpf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  tok_t tok_i,
  output tok_t tok_o
);

  tok_t        tok_r, tok_nxt;
  logic [7:0]  proto_r;
  logic [31:0] src_r;
  logic [31:0] dst_r;
  logic [15:0] port_r;
  logic [1:0]  act_r;
  logic [63:0] hits_r;
  logic [63:0] hits_inc;
  logic        in_use, fields_hit, hit, add_here, read_here;

  always_comb begin
    in_use     = tok_i.pos < tok_i.count;
    fields_hit = (proto_r == 8'd0  || proto_r == tok_i.proto) &&
                 (src_r   == 32'd0 || src_r   == tok_i.src)   &&
                 (dst_r   == 32'd0 || dst_r   == tok_i.dst)   &&
                 (port_r  == 16'd0 || port_r  == tok_i.port);
    hit        = tok_i.vld && (tok_i.op == OP_CLASSIFY) && !tok_i.found && in_use &&
                 fields_hit;
    add_here   = tok_i.vld && (tok_i.op == OP_ADD) && (tok_i.pos == tok_i.count);
    read_here  = tok_i.vld && (tok_i.op == OP_READ) &&
                 (16'(tok_i.idx) == 16'(tok_i.pos));
    hits_inc   = hits_r + 64'd1;

    tok_nxt     = tok_i;
    tok_nxt.pos = CNT_W'(tok_i.pos + 1'b1);
    if (hit) begin
      tok_nxt.found   = 1'b1;
      tok_nxt.verdict = act_r;
      tok_nxt.match   = CNT_W'(tok_i.pos + 1'b1);
      tok_nxt.hits    = hits_inc;
    end
    if (read_here) begin
      tok_nxt.hits = hits_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  // Rule storage: written on append, counter bumped on first match.
  always_ff @(posedge clk) begin
    if (add_here) begin
      proto_r <= tok_i.proto;
      src_r   <= tok_i.src;
      dst_r   <= tok_i.dst;
      port_r  <= tok_i.port;
      act_r   <= tok_i.act;
      hits_r  <= 64'd0;
    end else if (hit) begin
      hits_r <= hits_inc;
    end
  end

  assign tok_o = tok_r;

endmodule
